// ===== design/ile_pkg.sv =====
package ile_pkg;

	// Payload field widths (fixed by the request and result formats)
	localparam int unsigned FUNC_W   = 3;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned POS_W    = 6;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 7;

	typedef enum logic [FUNC_W-1:0] {
		FN_APPEND  = 3'd0,
		FN_HEAD    = 3'd1,
		FN_READ    = 3'd2,
		FN_DELETE  = 3'd3,
		FN_REVERSE = 3'd4
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RWAIT,
		S_DEL,
		S_FIN
	} state_t;

endpackage

// ===== design/ile_if.sv =====
interface ile_req_if
	import ile_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic        [FUNC_W-1:0]  func;
	logic signed [VALUE_W-1:0] value;
	logic        [POS_W-1:0]   position;

	modport source (output valid, func, value, position, input ready);
	modport sink   (input valid, func, value, position, output ready);
endinterface

interface ile_rsp_if
	import ile_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic        [STATUS_W-1:0] status;
	logic signed [VALUE_W-1:0]  read_value;
	logic        [COUNT_W-1:0]  element_count;

	modport source (output valid, status, read_value, element_count, input ready);
	modport sink   (input valid, status, read_value, element_count, output ready);
endinterface

// ===== design/indexed_list_engine_top.sv =====
// Channel  Dir  Payload                                   Beat
// -------  ---  ----------------------------------------  ----------------------
// req      in   func[2:0], value[31:0] s, position[5:0]   valid & ready, 1 request
// rsp      out  status[1:0], read_value[31:0] s,          valid & ready, 1 result
//               element_count[6:0]
//
// Sequence: the req beat enters EXEC; append, head insert, reverse, unused code
// and reject go on to FIN, a read goes through RWAIT, an in-range delete at p
// through DEL, moving one element per cycle (read slot i+1, write slot i in the
// next cycle). The result register loads in FIN, which then returns to IDLE.
// Reset: arst_n clears head slot, count, direction bit and control; RAM not cleared.
// Stalls: next request taken while a result waits; FIN holds only while rsp is full.
module indexed_list_engine_top
	import ile_pkg::*;
#(
	parameter int unsigned CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	ile_req_if.sink    req,
	ile_rsp_if.source  rsp
);

	localparam int unsigned IW = $clog2(CAPACITY);      // ring slot index
	localparam int unsigned CW = $clog2(CAPACITY + 1);  // element count
	localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

	localparam logic [IW:0]   CAP_X    = (IW + 1)'(CAPACITY);
	localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
	localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);

	state_t state_q, state_d;

	// List state
	logic [IW-1:0] first_q;
	logic [CW-1:0] count_q;
	logic          flip_q;

	// Latched request
	logic [FUNC_W-1:0]  func_q;
	logic [VALUE_W-1:0] value_q;
	logic [POS_W-1:0]   pos_q;

	// Pending result
	status_t            res_status_q;
	logic [VALUE_W-1:0] res_rd_q;

	// Output register
	logic               out_vld_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [VALUE_W-1:0]  out_rd_q;
	logic [COUNT_W-1:0]  out_cnt_q;

	// Delete sequencer: r_q is the next logical index to read, prev_slot_q is
	// the ring slot of r_q-1, the one its data lands in.
	logic [CW-1:0] r_q;
	logic [IW-1:0] prev_slot_q;
	logic          pend_s1;
	logic [IW-1:0] wslot_s1;

	// Element RAM, one write and one read port, registered read
	logic [VALUE_W-1:0] mem [CAPACITY];
	logic [VALUE_W-1:0] rdata_s1;
	logic               re, we;
	logic [IW-1:0]      raddr, waddr;
	logic [VALUE_W-1:0] wdata;

	logic          full, in_range, del_more, out_free;
	logic [IW-1:0] append_slot, pos_slot, rev_slot, r_slot, head_slot;

	// Ring slot of logical index p (p < CAPACITY)
	function automatic logic [IW-1:0] slot_of(
		input logic [IW-1:0] first,
		input logic          flip,
		input logic [CW-1:0] p
	);
		logic [IW:0] a, b, s;
		a = {1'b0, first};
		b = {1'b0, p[IW-1:0]};
		if (!flip) begin
			s = a + b;
			if (s >= CAP_X) begin
				s = s - CAP_X;
			end
		end else begin
			s = (a >= b) ? (a - b) : (a + CAP_X - b);
		end
		return s[IW-1:0];
	endfunction

	assign full        = (count_q == CAP_CNT);
	assign in_range    = (PW'(pos_q) < PW'(count_q));
	assign del_more    = (r_q < count_q);
	assign out_free    = !out_vld_q || rsp.ready;
	assign append_slot = slot_of(first_q, flip_q, count_q);
	assign pos_slot    = slot_of(first_q, flip_q, CW'(pos_q));
	assign rev_slot    = slot_of(first_q, flip_q, count_q - CW'(1));
	assign r_slot      = slot_of(first_q, flip_q, r_q);

	// New head slot for a head insert: one step against the list direction
	always_comb begin
		if (flip_q) begin
			head_slot = (first_q == LAST_IDX) ? '0 : first_q + IW'(1);
		end else begin
			head_slot = (first_q == '0) ? LAST_IDX : first_q - IW'(1);
		end
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = out_vld_q;
	assign rsp.status        = out_status_q;
	assign rsp.read_value    = out_rd_q;
	assign rsp.element_count = out_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM port control
	always_comb begin
		state_d = state_q;
		re      = 1'b0;
		raddr   = r_slot;
		we      = 1'b0;
		waddr   = wslot_s1;
		wdata   = rdata_s1;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_FIN;
				case (func_q)
					FN_APPEND: begin
						if (!full) begin
							we    = 1'b1;
							waddr = append_slot;
							wdata = value_q;
						end
					end
					FN_HEAD: begin
						if (!full) begin
							we    = 1'b1;
							waddr = head_slot;
							wdata = value_q;
						end
					end
					FN_READ: begin
						if (in_range) begin
							re      = 1'b1;
							raddr   = pos_slot;
							state_d = S_RWAIT;
						end
					end
					FN_DELETE: begin
						if (in_range) begin
							state_d = S_DEL;
						end
					end
					default: ;
				endcase
			end
			S_RWAIT: begin
				state_d = S_FIN;
			end
			S_DEL: begin
				re = del_more;
				we = pend_s1;
				if (!del_more && !pend_s1) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	// Request latch, sequencer addresses, pending result, output payload: no reset needed
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_q  <= req.func;
			value_q <= req.value;
			pos_q   <= req.position;
		end
		if (state_q == S_EXEC) begin
			res_rd_q     <= '0;
			res_status_q <= ST_OK;
			r_q          <= CW'(pos_q) + CW'(1);
			prev_slot_q  <= pos_slot;
			if ((func_q == FN_APPEND || func_q == FN_HEAD) && full) begin
				res_status_q <= ST_FULL;
			end
			if ((func_q == FN_READ || func_q == FN_DELETE) && !in_range) begin
				res_status_q <= ST_RANGE;
			end
		end
		if (state_q == S_RWAIT) begin
			res_rd_q <= rdata_s1;
		end
		if (state_q == S_DEL && del_more) begin
			r_q         <= r_q + CW'(1);
			prev_slot_q <= r_slot;
			wslot_s1    <= prev_slot_q;
		end
		if (state_q == S_FIN && out_free) begin
			out_status_q <= res_status_q;
			out_rd_q     <= res_rd_q;
			out_cnt_q    <= COUNT_W'(count_q);
		end
	end

	// List state, delete pipeline valid, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q   <= '0;
			count_q   <= '0;
			flip_q    <= 1'b0;
			pend_s1   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (state_q == S_EXEC) begin
				case (func_q)
					FN_APPEND: begin
						if (!full) begin
							count_q <= count_q + CW'(1);
						end
					end
					FN_HEAD: begin
						if (!full) begin
							first_q <= head_slot;
							count_q <= count_q + CW'(1);
						end
					end
					FN_REVERSE: begin
						if (count_q != '0) begin
							first_q <= rev_slot;
						end
						flip_q <= !flip_q;
					end
					default: ;
				endcase
			end
			pend_s1 <= (state_q == S_DEL) && del_more;
			if (state_q == S_DEL && !del_more && !pend_s1) begin
				count_q <= count_q - CW'(1);
			end
			if (state_q == S_FIN && out_free) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/ile_checker.sv =====
module ile_checker
	import ile_pkg::*;
#(
	parameter int unsigned CAPACITY = 64
) (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] status,
	input logic [VALUE_W-1:0]  read_value,
	input logic [COUNT_W-1:0]  element_count
);

	logic               seen_q;
	logic [COUNT_W-1:0] last_cnt_q;
	logic [COUNT_W-1:0] cnt_step;

	assign cnt_step = element_count - last_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			last_cnt_q <= '0;
		end else if (rsp_valid && rsp_ready) begin
			seen_q     <= 1'b1;
			last_cnt_q <= element_count;
		end
	end

	// A full report only comes with a full list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> element_count == COUNT_W'(CAPACITY))
		else $error("store-full status with count below capacity");

	// Only a good read carries data
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> read_value == '0)
		else $error("nonzero read value on failed request");

	// Successive results move the count by at most one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && seen_q |->
			cnt_step == '0 || cnt_step == COUNT_W'(1) || cnt_step == '1)
		else $error("element count jumped between results");

	// Stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=>
			rsp_valid && $stable(status) && $stable(read_value) && $stable(element_count))
		else $error("result beat changed while stalled");

endmodule

bind indexed_list_engine_top ile_checker #(.CAPACITY(CAPACITY)) u_ile_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.status        (rsp.status),
	.read_value    (rsp.read_value),
	.element_count (rsp.element_count)
);
